// ===== sv/bbep_pkg.sv =====
// Shared types, codes and defaults for the basic block edge profiler.
`default_nettype none
package bbep_pkg;

   localparam int NUM_BLOCKS_DEF   = 1024;
   localparam int LIST_ENTRIES_DEF = 15;

   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   localparam logic [1:0] ST_NONE   = 2'd0;
   localparam logic [1:0] ST_HIT    = 2'd1;
   localparam logic [1:0] ST_APPEND = 2'd2;
   localparam logic [1:0] ST_DROP   = 2'd3;

   typedef struct packed {
      logic        command;
      logic [9:0]  block_index;
      logic [31:0] block_offset;
      logic [7:0]  module_id;
      logic        ends_in_call;
      logic [31:0] call_offset;
      logic [3:0]  slot;
   } req_type;

   typedef struct packed {
      logic [31:0] block_count;
      logic [3:0]  pred_entries;
      logic [3:0]  caller_entries;
      logic [1:0]  pred_status;
      logic [1:0]  caller_status;
      logic [31:0] slot_pred_offset;
      logic [31:0] slot_pred_count;
      logic [31:0] slot_caller_offset;
      logic [31:0] slot_call_site;
      logic [31:0] slot_caller_count;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic clear;
      logic lookup;
      logic update;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } ctl_sts_type;

endpackage
`default_nettype wire

// ===== sv/bbep_ctrl.sv =====
// Controller state machine: memory clear sweep, lookup and update sequencing.
`default_nettype none
module bbep_ctrl
   import bbep_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   output logic             rsp_valid,
   output ctl_cmd_type      cmd,
   input  wire ctl_sts_type sts
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CLEAR  = 2'd1;
   localparam logic [1:0] S_LOOKUP = 2'd2;
   localparam logic [1:0] S_UPDATE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (start) state_in = S_LOOKUP;
         S_CLEAR:  if (sts.clear_last) state_in = S_IDLE;
         S_LOOKUP: state_in = S_UPDATE;
         S_UPDATE: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == S_UPDATE);
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = valid_ff;
   assign cmd.capture = start && (state_ff == S_IDLE);
   assign cmd.clear   = (state_ff == S_CLEAR);
   assign cmd.lookup  = (state_ff == S_LOOKUP);
   assign cmd.update  = (state_ff == S_UPDATE);

   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_LOOKUP))
      else $error("accepted item did not start lookup");
   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_UPDATE))
      else $error("result strobe without update");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held twice");

endmodule
`default_nettype wire

// ===== sv/bbep_dp.sv =====
// Datapath: block record memories, list compare and write-back, result register.
`default_nettype none
module bbep_dp
   import bbep_pkg::*;
#(
   parameter int NUM_BLOCKS   = NUM_BLOCKS_DEF,
   parameter int LIST_ENTRIES = LIST_ENTRIES_DEF
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctl_cmd_type cmd,
   output ctl_sts_type      sts,
   input  wire req_type     req_item,
   output rsp_type          rsp_item
);

   localparam int AW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int FW  = $clog2(LIST_ENTRIES + 1);
   localparam int LIW = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;

   // block records
   logic [31:0] cnt_mem   [NUM_BLOCKS];
   logic [FW-1:0] pfill_mem [NUM_BLOCKS];
   logic [FW-1:0] cfill_mem [NUM_BLOCKS];
   // list rows, one row per block
   logic [LIST_ENTRIES-1:0][31:0] paddr_mem [NUM_BLOCKS];
   logic [LIST_ENTRIES-1:0][31:0] phits_mem [NUM_BLOCKS];
   logic [LIST_ENTRIES-1:0][31:0] caddr_mem [NUM_BLOCKS];
   logic [LIST_ENTRIES-1:0][31:0] csite_mem [NUM_BLOCKS];
   logic [LIST_ENTRIES-1:0][31:0] chits_mem [NUM_BLOCKS];

   logic [31:0]   cnt_rd_ff;
   logic [FW-1:0] pfill_rd_ff, cfill_rd_ff;
   logic [LIST_ENTRIES-1:0][31:0] paddr_rd_ff, phits_rd_ff;
   logic [LIST_ENTRIES-1:0][31:0] caddr_rd_ff, csite_rd_ff, chits_rd_ff;

   req_type     req_ff;
   logic [AW-1:0] clr_ff;
   logic        last_valid_ff, last_was_call_ff;
   logic [31:0] last_offset_ff, last_call_site_ff;
   logic [7:0]  last_module_ff;
   rsp_type     rsp_ff, rsp_in;

   logic [AW-1:0] addr;
   logic          inb, rec, pedge, cedge, head_we, pwe, cwe;
   logic [31:0]   cnt_new;
   logic [FW-1:0] pfill_new, cfill_new;
   logic [LIST_ENTRIES-1:0][31:0] paddr_new, phits_new, caddr_new, csite_new, chits_new;
   logic [LIST_ENTRIES-1:0] pmatch, cmatch;
   logic [LIW-1:0] pidx, cidx, sidx;
   logic [1:0]    pst, cst;
   logic          sok_p, sok_c;

   assign addr = AW'(req_ff.block_index);
   assign inb  = (32'(req_ff.block_index) < 32'(NUM_BLOCKS));
   assign rec  = (req_ff.command == CMD_RECORD);
   assign sts.clear_last = (clr_ff == AW'(NUM_BLOCKS - 1));

   always_comb begin
      pedge = last_valid_ff && (last_module_ff == req_ff.module_id);
      cedge = pedge && last_was_call_ff;
      pidx = '0;
      cidx = '0;
      for (int i = LIST_ENTRIES - 1; i >= 0; i--) begin
         pmatch[i] = (i < int'(pfill_rd_ff)) && (paddr_rd_ff[i] == last_offset_ff);
         cmatch[i] = (i < int'(cfill_rd_ff)) && (caddr_rd_ff[i] == last_offset_ff);
         if (pmatch[i]) pidx = LIW'(i);
         if (cmatch[i]) cidx = LIW'(i);
      end

      paddr_new = paddr_rd_ff;
      phits_new = phits_rd_ff;
      pfill_new = pfill_rd_ff;
      pst = ST_NONE;
      if (pedge) begin
         if (|pmatch) begin
            phits_new[pidx] = phits_rd_ff[pidx] + 32'd1;
            pst = ST_HIT;
         end else if (int'(pfill_rd_ff) < LIST_ENTRIES) begin
            paddr_new[LIW'(pfill_rd_ff)] = last_offset_ff;
            phits_new[LIW'(pfill_rd_ff)] = 32'd1;
            pfill_new = pfill_rd_ff + FW'(1);
            pst = ST_APPEND;
         end else begin
            pst = ST_DROP;
         end
      end

      caddr_new = caddr_rd_ff;
      csite_new = csite_rd_ff;
      chits_new = chits_rd_ff;
      cfill_new = cfill_rd_ff;
      cst = ST_NONE;
      if (cedge) begin
         if (|cmatch) begin
            chits_new[cidx] = chits_rd_ff[cidx] + 32'd1;
            cst = ST_HIT;
         end else if (int'(cfill_rd_ff) < LIST_ENTRIES) begin
            caddr_new[LIW'(cfill_rd_ff)] = last_offset_ff;
            csite_new[LIW'(cfill_rd_ff)] = last_call_site_ff;
            chits_new[LIW'(cfill_rd_ff)] = 32'd1;
            cfill_new = cfill_rd_ff + FW'(1);
            cst = ST_APPEND;
         end else begin
            cst = ST_DROP;
         end
      end

      head_we = cmd.update && rec && inb;
      pwe     = head_we && pedge;
      cwe     = head_we && cedge;
      cnt_new = cnt_rd_ff + 32'd1;

      sidx  = LIW'(req_ff.slot);
      sok_p = (int'(req_ff.slot) < LIST_ENTRIES) && (int'(req_ff.slot) < int'(pfill_rd_ff));
      sok_c = (int'(req_ff.slot) < LIST_ENTRIES) && (int'(req_ff.slot) < int'(cfill_rd_ff));

      rsp_in = '0;
      if (inb) begin
         if (rec) begin
            rsp_in.block_count    = cnt_new;
            rsp_in.pred_entries   = 4'(pfill_new);
            rsp_in.caller_entries = 4'(cfill_new);
            rsp_in.pred_status    = pst;
            rsp_in.caller_status  = cst;
         end else begin
            rsp_in.block_count    = cnt_rd_ff;
            rsp_in.pred_entries   = 4'(pfill_rd_ff);
            rsp_in.caller_entries = 4'(cfill_rd_ff);
            if (sok_p) begin
               rsp_in.slot_pred_offset = paddr_rd_ff[sidx];
               rsp_in.slot_pred_count  = phits_rd_ff[sidx];
            end
            if (sok_c) begin
               rsp_in.slot_caller_offset = caddr_rd_ff[sidx];
               rsp_in.slot_call_site     = csite_rd_ff[sidx];
               rsp_in.slot_caller_count  = chits_rd_ff[sidx];
            end
         end
      end
   end

   // memories: clear sweep or write-back, registered reads
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         cnt_mem[clr_ff]   <= '0;
         pfill_mem[clr_ff] <= '0;
         cfill_mem[clr_ff] <= '0;
      end else if (head_we) begin
         cnt_mem[addr]   <= cnt_new;
         pfill_mem[addr] <= pfill_new;
         cfill_mem[addr] <= cfill_new;
      end
      if (pwe) begin
         paddr_mem[addr] <= paddr_new;
         phits_mem[addr] <= phits_new;
      end
      if (cwe) begin
         caddr_mem[addr] <= caddr_new;
         csite_mem[addr] <= csite_new;
         chits_mem[addr] <= chits_new;
      end
      if (cmd.lookup) begin
         cnt_rd_ff   <= cnt_mem[addr];
         pfill_rd_ff <= pfill_mem[addr];
         cfill_rd_ff <= cfill_mem[addr];
         paddr_rd_ff <= paddr_mem[addr];
         phits_rd_ff <= phits_mem[addr];
         caddr_rd_ff <= caddr_mem[addr];
         csite_rd_ff <= csite_mem[addr];
         chits_rd_ff <= chits_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_item;
      if (cmd.update) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff            <= '0;
         last_valid_ff     <= 1'b0;
         last_offset_ff    <= '0;
         last_module_ff    <= '0;
         last_was_call_ff  <= 1'b0;
         last_call_site_ff <= '0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + AW'(1);
         // every record item becomes the previous block, in range or not
         if (cmd.update && rec) begin
            last_valid_ff     <= 1'b1;
            last_offset_ff    <= req_ff.block_offset;
            last_module_ff    <= req_ff.module_id;
            last_was_call_ff  <= req_ff.ends_in_call;
            last_call_site_ff <= req_ff.call_offset;
         end
      end
   end

   assign rsp_item = rsp_ff;

endmodule
`default_nettype wire

// ===== sv/basic_block_edge_profiler.sv =====
// An accepted item passes through the lookup and update states, then the result strobe rises;
// busy is high until then, so no new item is taken before the last is written back. Each
// item reads its block record and list rows, compares all list entries at once and writes back.
// Reset: a clear sweep over all NUM_BLOCKS records zeroes counts and fills, busy high.
// The receiver cannot stall: each result is shown for one cycle under rsp_valid.
`default_nettype none
module basic_block_edge_profiler
   import bbep_pkg::*;
#(
   parameter int NUM_BLOCKS   = NUM_BLOCKS_DEF,
   parameter int LIST_ENTRIES = LIST_ENTRIES_DEF
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   bbep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   bbep_dp #(
      .NUM_BLOCKS   (NUM_BLOCKS),
      .LIST_ENTRIES (LIST_ENTRIES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule
`default_nettype wire
